>>> hw/rtl/dsps_pkg.sv
package dsps_pkg;

	localparam int PHASES             = 4;
	localparam int TURN_FRACTION_BITS = 8;
	localparam int TARGET_W           = 24;
	localparam int Q_BITS             = 15;
	localparam int CNT_W              = $clog2(Q_BITS + 1);

	localparam logic [Q_BITS-1:0]   TICK_BASE  = 15'd29297;
	localparam logic [TARGET_W-1:0] TARGET_MAX = {TARGET_W{1'b1}};

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_MOVE = 2'd1,
		MODE_TURN = 2'd2,
		MODE_STOP = 2'd3
	} mode_t;

	localparam logic REG_EXCITATION    = 1'b0;
	localparam logic REG_STEPS_PER_REV = 1'b1;

	localparam logic [15:0] STEPS_PER_REV_RESET = 16'd2048;

	// commands from the controller to the datapath
	typedef struct packed {
		logic take_tick;
		logic take_stop;
		logic take_hold;
		logic start;
		logic div_step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic running;
		logic res_valid;
	} dp_status_t;

	function automatic logic [3:0] rev_nibble(input logic [3:0] v);
		return {v[0], v[1], v[2], v[3]};
	endfunction

	// wave rows 1,2,4,8; full step rows 3,6,c,9
	function automatic logic [3:0] phase_pattern(input logic full, input logic [1:0] row);
		logic [3:0] p;
		p = 4'h0;
		if (full) begin
			unique case (row)
				2'd0: p = 4'h3;
				2'd1: p = 4'h6;
				2'd2: p = 4'hC;
				2'd3: p = 4'h9;
				default: p = 4'h0;
			endcase
		end else begin
			p = 4'h1 << row;
		end
		return p;
	endfunction

endpackage

>>> hw/rtl/dsps_ctrl.sv
module dsps_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic [1:0]           mode,
	input  logic                 res_stall,
	input  dsps_pkg::dp_status_t status,
	output dsps_pkg::dp_cmd_t    cmd
);
	import dsps_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_DIV
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_free;
	logic             take;

	// result slot is free, or its item leaves this cycle
	assign out_free  = !status.res_valid || !res_stall;
	assign cmd_stall = !((state_q == S_IDLE) && out_free);
	assign take      = cmd_valid && !cmd_stall;

	always_comb begin
		cmd = '0;
		if (take) begin
			unique case (mode_t'(mode))
				MODE_TICK: cmd.take_tick = 1'b1;
				MODE_STOP: cmd.take_stop = 1'b1;
				MODE_MOVE, MODE_TURN: begin
					if (status.running) cmd.take_hold = 1'b1;
					else                cmd.start     = 1'b1;
				end
				default: cmd = '0;
			endcase
		end
		if (state_q == S_DIV) begin
			if (cnt_q != '0)   cmd.div_step = 1'b1;
			else if (out_free) cmd.finish   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_DIV;
						cnt_q   <= CNT_W'(Q_BITS);
					end
				end
				S_DIV: begin
					if (cnt_q != '0)   cnt_q   <= cnt_q - 1'b1;
					else if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/dsps_datapath.sv
module dsps_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dsps_pkg::dp_cmd_t    cmd,
	output dsps_pkg::dp_status_t status,
	input  logic [1:0]           mode,
	input  logic signed [15:0]   turns,
	input  logic [7:0]           speed_rpm,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 res_stall,
	output logic                 res_valid,
	output logic [3:0]           coils_a,
	output logic [3:0]           coils_b,
	output logic                 busy_res,
	output logic                 stepped
);
	import dsps_pkg::*;

	// configuration
	logic        exc_mode_q;
	logic [15:0] spr_q;

	// motion state
	logic [TARGET_W-1:0] steps_done_q;
	logic [TARGET_W-1:0] steps_target_q;
	logic [Q_BITS-1:0]   interval_q;
	logic [Q_BITS-1:0]   countdown_q;
	logic [1:0]          kind_q;
	logic                running_q;
	logic [7:0]          coil_q;

	// command operands and interval divider
	logic [15:0]       mag_q;
	logic              neg_q;
	logic              turn_q;
	logic [7:0]        divisor_q;
	logic [7:0]        rem_q;
	logic [Q_BITS-1:0] quot_q;
	logic [31:0]       prod_q;

	// result register
	logic       res_valid_q;
	logic [7:0] res_coil_q;
	logic       res_busy_q;
	logic       res_stepped_q;

	logic [8:0]          div_trial;
	logic                div_ge;
	logic [31:0]         prod_sh;
	logic [TARGET_W:0]   tgt_sum;
	logic [TARGET_W-1:0] tgt_sat;
	logic [Q_BITS-1:0]   cd_dec;
	logic                expired;
	logic                more_steps;
	logic                tick_step;
	logic                tick_end;
	logic                apply;
	logic [TARGET_W-1:0] sd_base;
	logic [TARGET_W-1:0] sd_new;
	logic [1:0]          kind_src;
	logic [Q_BITS-1:0]   intv_src;
	logic [3:0]          pat;
	logic [3:0]          pat_s;
	logic [3:0]          pat_r;
	logic [3:0]          nib_a;
	logic [3:0]          nib_b;
	logic [7:0]          coil_next;
	logic                running_next;
	logic                load_res;

	// restoring divider: quot_q starts as the dividend and fills with quotient bits
	assign div_trial = {rem_q, quot_q[Q_BITS-1]};
	assign div_ge    = div_trial >= {1'b0, divisor_q};

	assign prod_sh = prod_q >> TURN_FRACTION_BITS;
	assign tgt_sum = {1'b0, prod_sh[TARGET_W-1:0]} + 1'b1;
	assign tgt_sat = ((prod_sh[31:TARGET_W] != '0) || tgt_sum[TARGET_W]) ? TARGET_MAX :
		tgt_sum[TARGET_W-1:0];

	assign cd_dec     = (countdown_q == '0) ? '0 : countdown_q - 1'b1;
	assign expired    = (cd_dec == '0);
	assign more_steps = steps_done_q < steps_target_q;
	assign tick_step  = cmd.take_tick && running_q && expired && more_steps;
	assign tick_end   = cmd.take_tick && running_q && expired && !more_steps;
	assign apply      = tick_step || cmd.finish;

	always_comb begin
		sd_base  = steps_done_q;
		kind_src = kind_q;
		intv_src = interval_q;
		if (cmd.finish) begin
			sd_base  = '0;
			kind_src = {neg_q, turn_q};
			intv_src = quot_q;
		end
	end

	assign sd_new = sd_base + 1'b1;
	assign pat    = phase_pattern(exc_mode_q, sd_new[1:0]);
	assign pat_s  = pat;
	assign pat_r  = rev_nibble(pat);

	// kind bit0 turn, bit1 reversed sense
	always_comb begin
		if (kind_src[0]) begin
			nib_a = kind_src[1] ? pat_r : pat_s;
			nib_b = nib_a;
		end else begin
			nib_a = kind_src[1] ? pat_s : pat_r;
			nib_b = kind_src[1] ? pat_r : pat_s;
		end
	end

	always_comb begin
		coil_next    = coil_q;
		running_next = running_q;
		if (cmd.take_stop) begin
			coil_next    = '0;
			running_next = 1'b0;
		end else if (apply) begin
			coil_next    = {nib_b, nib_a};
			running_next = 1'b1;
		end else if (tick_end) begin
			running_next = 1'b0;
		end
	end

	assign load_res = cmd.take_tick || cmd.take_stop || cmd.take_hold || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exc_mode_q <= 1'b0;
			spr_q      <= STEPS_PER_REV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXCITATION:    exc_mode_q <= cfg_data[0];
				REG_STEPS_PER_REV: spr_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_done_q   <= '0;
			steps_target_q <= '0;
			interval_q     <= '0;
			countdown_q    <= '0;
			kind_q         <= '0;
			running_q      <= 1'b0;
			coil_q         <= '0;
		end else begin
			coil_q    <= coil_next;
			running_q <= running_next;
			if (cmd.take_stop) begin
				countdown_q <= '0;
			end else if (apply) begin
				steps_done_q <= sd_new;
				countdown_q  <= intv_src;
			end else if (cmd.take_tick && running_q) begin
				countdown_q <= cd_dec;
			end
			if (cmd.finish) begin
				steps_target_q <= tgt_sat;
				interval_q     <= quot_q;
				kind_q         <= {neg_q, turn_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mag_q     <= turns[15] ? 16'(-turns) : turns;
			neg_q     <= turns[15];
			turn_q    <= (mode_t'(mode) == MODE_TURN);
			divisor_q <= (speed_rpm == '0) ? 8'd1 : speed_rpm;
			rem_q     <= '0;
			quot_q    <= TICK_BASE;
		end else if (cmd.div_step) begin
			rem_q  <= div_ge ? 8'(div_trial - {1'b0, divisor_q}) : div_trial[7:0];
			quot_q <= {quot_q[Q_BITS-2:0], div_ge};
			prod_q <= 32'(mag_q) * 32'(spr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_coil_q    <= coil_next;
			res_busy_q    <= running_next;
			res_stepped_q <= apply;
		end
	end

	assign status.running   = running_q;
	assign status.res_valid = res_valid_q;
	assign res_valid        = res_valid_q;
	assign coils_a          = res_coil_q[3:0];
	assign coils_b          = res_coil_q[7:4];
	assign busy_res         = res_busy_q;
	assign stepped          = res_stepped_q;

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stepped_q |-> res_busy_q)
		else $error("step reported while idle");

	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> steps_done_q <= steps_target_q)
		else $error("steps done passed target");

	a_finish_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> running_q && steps_done_q == TARGET_W'(1))
		else $error("command did not start with step one");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_stop |=> !running_q && coil_q == '0 && countdown_q == '0)
		else $error("stop left motion state");

endmodule

>>> hw/rtl/dual_stepper_phase_sequencer.sv
// channel   signals                                     accepted when
// cmd       cmd_valid cmd_stall mode turns speed_rpm    cmd_valid && !cmd_stall
// res       res_valid res_stall coils_a coils_b         res_valid && !res_stall
//           busy_res stepped
// cfg       cfg_we cfg_index cfg_data                   cfg_we
//
// tick, stop and a command that arrives while busy are handled without the divider
// a move or turn started from idle holds off new commands while the step interval
// comes from a bit-serial divider, one quotient bit per cycle
// reset clears the motion state and coils and loads the register defaults
// an item is taken only while the result register is empty or being drained
module dual_stepper_phase_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         mode,
	input  logic signed [15:0] turns,
	input  logic [7:0]         speed_rpm,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [3:0]         coils_a,
	output logic [3:0]         coils_b,
	output logic               busy_res,
	output logic               stepped,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);
	import dsps_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	dsps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.mode      (mode),
		.res_stall (res_stall),
		.status    (status),
		.cmd       (cmd)
	);

	dsps_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.mode      (mode),
		.turns     (turns),
		.speed_rpm (speed_rpm),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.coils_a   (coils_a),
		.coils_b   (coils_b),
		.busy_res  (busy_res),
		.stepped   (stepped)
	);

endmodule
